[rtl/core/soa_pkg.sv]
// Shared types and constants for the stable oscillation averager.
// Used by the front, queue, divider and top-level modules; no dependencies.
package soa_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 16;
  localparam int SUM_W     = 32;
  localparam int AVG_W     = 24;
  localparam int FRAC_W    = 8;
  localparam int DIVD_W    = SUM_W + FRAC_W;
  localparam int DIV_STEPS = DIVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [COUNT_W-1:0] TURNS_RESET = 16'd8;
  localparam logic [AVG_W-1:0]   AVG_MAX_Q8  = 24'hFFFF00;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  // Direction and trend codes, two's complement of +1 / -1 / 0.
  localparam logic [1:0] DIR_FLAT = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_TRACK  = 3'b100
  } soa_phase_t;

  typedef enum logic [1:0] {
    DV_IDLE = 2'b01,
    DV_RUN  = 2'b10
  } soa_div_state_t;

  // One averaging job handed from the front to the divider.
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] divisor;
  } soa_job_t;

  // Status flags of a queue, read by its producer and its consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } soa_q_status_t;

endpackage

[rtl/core/soa_front.sv]
// Front part: takes speed samples, tracks direction, turns and trends,
// and pushes a finished sum and divisor into the job queue. Uses soa_pkg.
module soa_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [soa_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [soa_pkg::SAMPLE_W-1:0] in_speed_sample,
  input  soa_pkg::soa_q_status_t      q_status,
  output logic                        q_push,
  output soa_pkg::soa_job_t           q_job
);
  import soa_pkg::*;

  logic [COUNT_W-1:0]  turns_needed_r;
  soa_phase_t          phase_r, phase_nxt;
  logic [SAMPLE_W-1:0] last_sample_r, last_sample_nxt;
  logic [1:0]          direction_r, direction_nxt;
  logic [1:0]          valley_trend_r, valley_trend_nxt;
  logic [1:0]          peak_trend_r, peak_trend_nxt;
  logic [1:0]          joint_trend_r, joint_trend_nxt;
  logic                have_valley_r, have_valley_nxt;
  logic                have_peak_r, have_peak_nxt;
  logic [SAMPLE_W-1:0] last_valley_r, last_valley_nxt;
  logic [SAMPLE_W-1:0] last_peak_r, last_peak_nxt;
  logic [COUNT_W-1:0]  turn_count_r, turn_count_nxt;
  logic [SUM_W-1:0]    running_sum_r, running_sum_nxt;

  logic [SAMPLE_W-1:0] s;
  logic                accept;
  logic                rising;
  logic                turn;
  logic                other_seen;
  logic                steady;
  logic [COUNT_W-1:0]  divisor;
  logic [SUM_W-1:0]    job_sum;

  assign s        = in_speed_sample;
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign rising   = s > last_sample_r;
  assign divisor  = (turns_needed_r == '0) ? COUNT_W'(1) : turns_needed_r;

  always_comb begin
    phase_nxt        = phase_r;
    last_sample_nxt  = last_sample_r;
    direction_nxt    = direction_r;
    valley_trend_nxt = valley_trend_r;
    peak_trend_nxt   = peak_trend_r;
    joint_trend_nxt  = joint_trend_r;
    have_valley_nxt  = have_valley_r;
    have_peak_nxt    = have_peak_r;
    last_valley_nxt  = last_valley_r;
    last_peak_nxt    = last_peak_r;
    turn_count_nxt   = turn_count_r;
    running_sum_nxt  = running_sum_r;
    turn             = 1'b0;
    other_seen       = 1'b0;
    steady           = 1'b0;
    q_push           = 1'b0;
    job_sum          = '0;

    // A sample equal to the previous one is dropped without a trace.
    if (accept && (s != last_sample_r)) begin
      last_sample_nxt = s;
      unique case (phase_r)
        PH_FIRST: begin
          phase_nxt = PH_SECOND;
        end
        PH_SECOND: begin
          direction_nxt = rising ? DIR_UP : DIR_DOWN;
          phase_nxt     = PH_TRACK;
        end
        PH_TRACK: begin
          if (rising && (direction_r != DIR_UP)) begin
            direction_nxt = DIR_UP;
            if (!have_valley_r) begin
              have_valley_nxt = 1'b1;
            end else begin
              valley_trend_nxt = (s > last_valley_r) ? DIR_UP :
                                 (s < last_valley_r) ? DIR_DOWN : DIR_FLAT;
              turn       = 1'b1;
              other_seen = have_peak_r;
            end
            last_valley_nxt = s;
          end else if (!rising && (direction_r != DIR_DOWN)) begin
            direction_nxt = DIR_DOWN;
            if (!have_peak_r) begin
              have_peak_nxt = 1'b1;
            end else begin
              peak_trend_nxt = (s > last_peak_r) ? DIR_UP :
                               (s < last_peak_r) ? DIR_DOWN : DIR_FLAT;
              turn       = 1'b1;
              other_seen = have_valley_r;
            end
            last_peak_nxt = s;
          end

          steady = ((peak_trend_nxt == DIR_UP) && (valley_trend_nxt == DIR_UP) &&
                    (joint_trend_r == DIR_UP)) ||
                   ((peak_trend_nxt == DIR_DOWN) && (valley_trend_nxt == DIR_DOWN) &&
                    (joint_trend_r == DIR_DOWN));

          if (turn) begin
            if (other_seen && !steady) begin
              if (turn_count_r != COUNT_MAX) begin
                turn_count_nxt = turn_count_r + COUNT_W'(1);
              end
              running_sum_nxt = running_sum_r + SUM_W'(s);
              if ((peak_trend_nxt == DIR_UP) && (valley_trend_nxt == DIR_UP)) begin
                joint_trend_nxt = DIR_UP;
              end else if ((peak_trend_nxt == DIR_DOWN) &&
                           (valley_trend_nxt == DIR_DOWN)) begin
                joint_trend_nxt = DIR_DOWN;
              end else begin
                joint_trend_nxt = DIR_FLAT;
              end
            end else begin
              turn_count_nxt  = '0;
              running_sum_nxt = '0;
            end
          end

          // Enough turns collected: hand the job off and rearm.
          if (turn_count_nxt >= divisor) begin
            q_push           = 1'b1;
            job_sum          = running_sum_nxt;
            phase_nxt        = PH_FIRST;
            last_sample_nxt  = '0;
            direction_nxt    = DIR_FLAT;
            valley_trend_nxt = DIR_FLAT;
            peak_trend_nxt   = DIR_FLAT;
            joint_trend_nxt  = DIR_FLAT;
            have_valley_nxt  = 1'b0;
            have_peak_nxt    = 1'b0;
            last_valley_nxt  = '0;
            last_peak_nxt    = '0;
            turn_count_nxt   = '0;
            running_sum_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase
    end
  end

  // The pushed sum is the one before the rearm clears it.
  assign q_job.sum     = job_sum;
  assign q_job.divisor = divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turns_needed_r <= TURNS_RESET;
      phase_r        <= PH_FIRST;
      last_sample_r  <= '0;
      direction_r    <= DIR_FLAT;
      valley_trend_r <= DIR_FLAT;
      peak_trend_r   <= DIR_FLAT;
      joint_trend_r  <= DIR_FLAT;
      have_valley_r  <= 1'b0;
      have_peak_r    <= 1'b0;
      last_valley_r  <= '0;
      last_peak_r    <= '0;
      turn_count_r   <= '0;
      running_sum_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        turns_needed_r <= cfg_wr_data;
      end
      phase_r        <= phase_nxt;
      last_sample_r  <= last_sample_nxt;
      direction_r    <= direction_nxt;
      valley_trend_r <= valley_trend_nxt;
      peak_trend_r   <= peak_trend_nxt;
      joint_trend_r  <= joint_trend_nxt;
      have_valley_r  <= have_valley_nxt;
      have_peak_r    <= have_peak_nxt;
      last_valley_r  <= last_valley_nxt;
      last_peak_r    <= last_peak_nxt;
      turn_count_r   <= turn_count_nxt;
      running_sum_r  <= running_sum_nxt;
    end
  end

endmodule

[rtl/core/soa_queue.sv]
// Short job queue between the front and the divider.
// Holds soa_job_t entries from soa_pkg; head entry is shown without a read delay.
module soa_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  soa_pkg::soa_job_t      push_job,
  input  logic                   pop,
  output soa_pkg::soa_job_t      head_job,
  output soa_pkg::soa_q_status_t status
);
  import soa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  soa_job_t           entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (fill_r == CNT_W'(DEPTH));
  assign status.empty = (fill_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/core/soa_divider.sv]
// Back part: restoring divider for sum*256/divisor, one quotient bit a cycle,
// with saturation and the output register. Uses soa_pkg.
module soa_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  soa_pkg::soa_q_status_t      q_status,
  input  soa_pkg::soa_job_t           q_job,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [soa_pkg::AVG_W-1:0]   out_average_q8
);
  import soa_pkg::*;

  soa_div_state_t      state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DIVD_W-1:0]   shreg_r, shreg_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  logic [COUNT_W-1:0]  div_r, div_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0]    out_avg_r, out_avg_nxt;

  logic [COUNT_W:0]    trial;
  logic                fits;
  logic                finished;
  logic                out_free;
  logic [AVG_W-1:0]    quot_sat;

  assign trial    = {rem_r, shreg_r[DIVD_W-1]};
  assign fits     = trial >= {1'b0, div_r};
  assign finished = (step_r == STEP_W'(DIV_STEPS));
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == DV_IDLE) && !q_status.empty;

  // Quotients above 0xFFFF00 (65535.0 in Q16.8) clamp to that value.
  assign quot_sat = ((|shreg_r[DIVD_W-1:AVG_W]) || (shreg_r[AVG_W-1:0] > AVG_MAX_Q8)) ?
                    AVG_MAX_Q8 : shreg_r[AVG_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    shreg_nxt     = shreg_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_avg_nxt   = out_avg_r;

    unique case (state_r)
      DV_IDLE: begin
        if (q_pop) begin
          shreg_nxt = {q_job.sum, FRAC_W'(0)};
          div_nxt   = q_job.divisor;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        if (!finished) begin
          rem_nxt   = fits ? COUNT_W'(trial - {1'b0, div_r}) : trial[COUNT_W-1:0];
          shreg_nxt = {shreg_r[DIVD_W-2:0], fits};
          step_nxt  = step_r + STEP_W'(1);
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = quot_sat;
          state_nxt     = DV_IDLE;
        end
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DV_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r   <= shreg_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    out_avg_r <= out_avg_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_average_q8 = out_avg_r;

endmodule

[rtl/core/stable_oscillation_averager.sv]
// Stable oscillation averager: one speed item is accepted per cycle while the job
// queue has room. A closing item's average passes the queue, the 40 divider steps
// and the output register; the divider pops the next job only after it has loaded
// the last result into the output register, which out_stall can hold. Synchronous
// active-low reset clears all tracking state, empties the queue and loads
// turns_needed with 8.
module stable_oscillation_averager #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_speed_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_average_q8
);
  import soa_pkg::*;

  soa_job_t      push_job;
  soa_job_t      head_job;
  soa_q_status_t q_status;
  logic          q_push;
  logic          q_pop;

  soa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_speed_sample (in_speed_sample),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  soa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  soa_divider u_divider (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .q_job          (head_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average_q8 (out_average_q8)
  );

endmodule
